@@ design/r2fft_pkg.sv @@
// Shared types, constants and helper functions of the radix-2 FFT engine
package r2fft_pkg;

  localparam int MaxLog2 = 6;
  localparam int Depth   = 1 << MaxLog2;
  localparam int AddrW   = MaxLog2;
  localparam int DataW   = 23;
  localparam int WordW   = 2 * DataW;
  localparam int CntW    = MaxLog2 + 1;
  localparam int TwW     = 17;
  localparam int ProdW   = DataW + TwW;

  localparam logic [DataW-1:0] OutMax = 23'sh3FFFFF;
  localparam logic [DataW-1:0] OutMin = 23'sh400000;

  localparam logic [0:0] CfgLog2 = 1'b0;
  localparam logic [0:0] CfgInv  = 1'b1;

  typedef enum logic [3:0] {
    ST_LOAD, ST_PERM_RD, ST_PERM_WR, ST_BF_RDA, ST_BF_RDB, ST_BF_MUL0,
    ST_BF_MUL1, ST_BF_WRA, ST_BF_WRB, ST_OUT_RD, ST_OUT_HOLD
  } state_t;

  // Quarter-wave cosine table, round(32768*cos(2*pi*k/64))
  function automatic logic [TwW-1:0] qcos(input logic [4:0] k);
    logic [TwW-1:0] v;
    begin
      v = '0;
      unique case (k)
        5'd0:  v = 17'd32768; 5'd1:  v = 17'd32610; 5'd2:  v = 17'd32138;
        5'd3:  v = 17'd31357; 5'd4:  v = 17'd30274; 5'd5:  v = 17'd28899;
        5'd6:  v = 17'd27246; 5'd7:  v = 17'd25330; 5'd8:  v = 17'd23170;
        5'd9:  v = 17'd20788; 5'd10: v = 17'd18205; 5'd11: v = 17'd15447;
        5'd12: v = 17'd12540; 5'd13: v = 17'd9512;  5'd14: v = 17'd6393;
        5'd15: v = 17'd3212;  default: v = 17'd0;
      endcase
      return v;
    end
  endfunction

  // Saturate a wide sum to the 23-bit result range
  function automatic logic [DataW-1:0] sat23(input logic signed [DataW+1:0] v);
    begin
      if (v > $signed({{2{1'b0}}, OutMax})) return OutMax;
      else if (v < $signed({{2{1'b1}}, OutMin})) return OutMin;
      else return v[DataW-1:0];
    end
  endfunction

endpackage

@@ design/r2fft_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data
module r2fft_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  // Write, then register the read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/r2fft_bfly.sv @@
// Shared butterfly datapath: twiddle lookup, complex multiply (real part, then imaginary), add/sub
module r2fft_bfly
  import r2fft_pkg::*;
(
  input  logic                    clk,
  input  logic                    mul_sel,
  input  logic [4:0]              tw_idx,
  input  logic signed [DataW-1:0] br,
  input  logic signed [DataW-1:0] bi,
  input  logic signed [DataW-1:0] ar,
  input  logic signed [DataW-1:0] ai,
  output logic [DataW-1:0]        sum_re,
  output logic [DataW-1:0]        sum_im,
  output logic [DataW-1:0]        dif_re,
  output logic [DataW-1:0]        dif_im
);

  logic signed [TwW-1:0]     c, s;
  logic signed [TwW-1:0]     cf, sf;
  logic signed [DataW-1:0]   mx;
  logic signed [ProdW-1:0]   pc, ps;
  logic signed [ProdW-1:0]   pcr_r, psr_r, pci_r, psi_r;
  logic signed [ProdW+1:0]   tr_w, ti_w;
  logic signed [DataW+1:0]   tr, ti;

  // Twiddle for angle 2*pi*k/64, k below 32
  always_comb begin
    if (tw_idx <= 5'd16) begin
      c = $signed(qcos(tw_idx));
      s = $signed(qcos(5'd16 - tw_idx));
    end else begin
      c = -$signed(qcos(5'd0 - tw_idx));
      s = $signed(qcos(tw_idx - 5'd16));
    end
    cf = c;
    sf = s;
  end

  // One operand pair per cycle: real part first, then imaginary
  assign mx = mul_sel ? bi : br;
  assign pc = cf * mx;
  assign ps = sf * mx;

  always_ff @(posedge clk) begin
    if (!mul_sel) begin
      pcr_r <= pc;
      psr_r <= ps;
    end else begin
      pci_r <= pc;
      psi_r <= ps;
    end
  end

  // Round the rotated value and form sum and difference
  assign tr_w = ({{2{pcr_r[ProdW-1]}}, pcr_r} + {{2{psi_r[ProdW-1]}}, psi_r}
                + (ProdW+2)'(16384)) >>> 15;
  assign ti_w = ({{2{pci_r[ProdW-1]}}, pci_r} - {{2{psr_r[ProdW-1]}}, psr_r}
                + (ProdW+2)'(16384)) >>> 15;
  assign tr = tr_w[DataW+1:0];
  assign ti = ti_w[DataW+1:0];

  assign sum_re = sat23({{2{ar[DataW-1]}}, ar} + tr);
  assign sum_im = sat23({{2{ai[DataW-1]}}, ai} + ti);
  assign dif_re = sat23({{2{ar[DataW-1]}}, ar} - tr);
  assign dif_im = sat23({{2{ai[DataW-1]}}, ai} - ti);

endmodule

@@ design/radix2_fft_engine_unit.sv @@
// Radix-2 decimation-in-time FFT engine top level: sequencer, store and output
// Samples load one per cycle into a 64-entry store. After the last sample of
// 2^log2_points (1..6, out-of-range values clamp) the engine copies the store in
// bit-reversed order into a work buffer (a read, then a write, per point), runs
// the butterflies on one shared complex multiplier (N/2*log2 N of them, each
// through read A, read B, multiply real, multiply imaginary, write A, write B),
// then emits the bins in order, one read and one hold state per bin, waiting
// while the output is stalled. No sample is taken between the last load and the
// last bin. The inverse-mode setting is sampled with the last sample loaded.
module radix2_fft_engine_unit
  import r2fft_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [0:0]        cfg_index,
  input  logic [2:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [15:0] in_sample_re,
  input  logic signed [15:0] in_sample_im,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [22:0] out_bin_re,
  output logic signed [22:0] out_bin_im,
  output logic              out_last_bin
);

  state_t state_r, state_nxt;
  logic [2:0]      log2_r;
  logic            inv_r, inv_run_r;
  logic [2:0]      len_r;
  logic [CntW-1:0] load_cnt_r;
  logic [AddrW-1:0] idx_r;
  logic [2:0]      stg_r;
  logic [AddrW-1:0] bf_r;
  logic signed [DataW-1:0] ar_r, ai_r, br_r, bi_r;
  logic [DataW-1:0] out_re_r, out_im_r;
  logic            out_valid_r, out_last_r;

  logic [2:0]       len_eff;
  logic [CntW-1:0]  n_eff;
  logic             in_acc;
  logic             st_we, wk_we;
  logic [AddrW-1:0] st_waddr, st_raddr, wk_waddr, wk_raddr;
  logic [WordW-1:0] st_wdata, st_rdata, wk_wdata, wk_rdata;
  logic [AddrW-1:0] half, a_idx, b_idx, rev_idx, jj;
  logic [4:0]       tw_idx;
  logic [DataW-1:0] sre, sim, dre, dim;
  logic             bf_last, stg_last;
  logic signed [DataW:0] neg_im;
  logic signed [DataW:0] ore, oim;
  logic signed [DataW-1:0] br_in;

  // Clamp the configured length
  always_comb begin
    if (log2_r == 3'd0) len_eff = 3'd1;
    else if (log2_r > 3'(MaxLog2)) len_eff = 3'(MaxLog2);
    else len_eff = log2_r;
    n_eff = CntW'(1) << len_eff;
  end

  assign in_stall = (state_r != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;

  // Bit-reverse idx_r over len_r bits
  always_comb begin
    rev_idx = '0;
    for (int b = 0; b < MaxLog2; b++) begin
      if (b < int'(len_r)) rev_idx[int'(len_r) - 1 - b] = idx_r[b];
    end
  end

  // Butterfly addressing: bf_r counts butterflies within a stage
  always_comb begin
    half  = AddrW'(1) << stg_r;
    jj    = bf_r & (half - AddrW'(1));
    a_idx = ((bf_r >> stg_r) << (stg_r + 3'd1)) | jj;
    b_idx = a_idx | half;
    tw_idx = 5'(jj << (3'd5 - stg_r));
    bf_last  = (CntW'(bf_r) == ((CntW'(1) << len_r) >> 1) - CntW'(1));
    stg_last = (stg_r == len_r - 3'd1);
  end

  r2fft_ram #(.Width(WordW), .Depth(Depth)) u_store (
    .clk(clk), .wr_en(st_we), .wr_addr(st_waddr), .wr_data(st_wdata),
    .rd_addr(st_raddr), .rd_data(st_rdata)
  );

  r2fft_ram #(.Width(WordW), .Depth(Depth)) u_work (
    .clk(clk), .wr_en(wk_we), .wr_addr(wk_waddr), .wr_data(wk_wdata),
    .rd_addr(wk_raddr), .rd_data(wk_rdata)
  );

  // Feed the real part of b straight from the buffer in the first multiply cycle
  assign br_in = (state_r == ST_BF_MUL0) ? $signed(wk_rdata[WordW-1:DataW]) : br_r;

  r2fft_bfly u_bfly (
    .clk(clk), .mul_sel(state_r == ST_BF_MUL1), .tw_idx(tw_idx),
    .br(br_in), .bi(bi_r), .ar(ar_r), .ai(ai_r),
    .sum_re(sre), .sum_im(sim), .dif_re(dre), .dif_im(dim)
  );

  // Memory port control
  assign neg_im = -$signed({st_rdata[DataW-1], st_rdata[DataW-1:0]});
  always_comb begin
    st_we    = in_acc && (load_cnt_r < CntW'(Depth));
    st_waddr = load_cnt_r[AddrW-1:0];
    st_wdata = {DataW'(in_sample_re), DataW'(in_sample_im)};
    st_raddr = rev_idx;
    wk_we    = 1'b0;
    wk_waddr = idx_r;
    wk_wdata = st_rdata;
    wk_raddr = idx_r;
    unique case (state_r)
      ST_PERM_WR: begin
        wk_we = 1'b1;
        if (inv_run_r) wk_wdata = {st_rdata[WordW-1:DataW], neg_im[DataW-1:0]};
      end
      ST_BF_RDA:  wk_raddr = a_idx;
      ST_BF_RDB:  wk_raddr = b_idx;
      ST_BF_WRA: begin
        wk_we = 1'b1; wk_waddr = a_idx; wk_wdata = {sre, sim};
      end
      ST_BF_WRB: begin
        wk_we = 1'b1; wk_waddr = b_idx; wk_wdata = {dre, dim};
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:     if (in_acc && (load_cnt_r + CntW'(1) >= n_eff)) state_nxt = ST_PERM_RD;
      ST_PERM_RD:  state_nxt = ST_PERM_WR;
      ST_PERM_WR:  state_nxt = (CntW'(idx_r) == (CntW'(1) << len_r) - CntW'(1))
                               ? ST_BF_RDA : ST_PERM_RD;
      ST_BF_RDA:   state_nxt = ST_BF_RDB;
      ST_BF_RDB:   state_nxt = ST_BF_MUL0;
      ST_BF_MUL0:  state_nxt = ST_BF_MUL1;
      ST_BF_MUL1:  state_nxt = ST_BF_WRA;
      ST_BF_WRA:   state_nxt = ST_BF_WRB;
      ST_BF_WRB:   state_nxt = (bf_last && stg_last) ? ST_OUT_RD : ST_BF_RDA;
      ST_OUT_RD:   state_nxt = ST_OUT_HOLD;
      ST_OUT_HOLD: if (!out_valid_r || !out_stall) begin
        state_nxt = (CntW'(idx_r) == (CntW'(1) << len_r) - CntW'(1))
                    ? ST_LOAD : ST_OUT_RD;
      end
      default:     state_nxt = ST_LOAD;
    endcase
  end

  // Output scaling and conjugation for inverse mode
  always_comb begin
    ore = $signed({wk_rdata[WordW-1], wk_rdata[WordW-1:DataW]});
    oim = $signed({wk_rdata[DataW-1], wk_rdata[DataW-1:0]});
    if (inv_run_r) begin
      ore = ore >>> len_r;
      oim = (-oim) >>> len_r;
    end
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      log2_r      <= 3'(MaxLog2);
      inv_r       <= 1'b0;
      inv_run_r   <= 1'b0;
      len_r       <= 3'(MaxLog2);
      load_cnt_r  <= '0;
      idx_r       <= '0;
      stg_r       <= '0;
      bf_r        <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        if (cfg_index == CfgLog2) log2_r <= cfg_data;
        else inv_r <= cfg_data[0];
      end
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_LOAD: if (in_acc) begin
          if (load_cnt_r + CntW'(1) >= n_eff) begin
            load_cnt_r <= '0;
            len_r      <= len_eff;
            inv_run_r  <= inv_r;
            idx_r      <= '0;
          end else begin
            load_cnt_r <= load_cnt_r + CntW'(1);
          end
        end
        ST_PERM_WR: begin
          idx_r <= idx_r + AddrW'(1);
          stg_r <= '0;
          bf_r  <= '0;
        end
        ST_BF_WRB: begin
          if (bf_last) begin
            bf_r  <= '0;
            stg_r <= stg_r + 3'd1;
          end else begin
            bf_r <= bf_r + AddrW'(1);
          end
          idx_r <= '0;
        end
        ST_OUT_HOLD: if (!out_valid_r || !out_stall) begin
          out_valid_r <= 1'b1;
          out_last_r  <= (CntW'(idx_r) == (CntW'(1) << len_r) - CntW'(1));
          idx_r       <= idx_r + AddrW'(1);
        end
        default: ;
      endcase
      if (state_r == ST_LOAD && out_valid_r && !out_stall) out_last_r <= 1'b0;
    end
  end

  // Operand and output payload registers
  always_ff @(posedge clk) begin
    if (state_r == ST_BF_RDB) begin
      ar_r <= $signed(wk_rdata[WordW-1:DataW]);
      ai_r <= $signed(wk_rdata[DataW-1:0]);
    end
    if (state_r == ST_BF_MUL0) begin
      br_r <= $signed(wk_rdata[WordW-1:DataW]);
      bi_r <= $signed(wk_rdata[DataW-1:0]);
    end
    if (state_r == ST_OUT_HOLD && (!out_valid_r || !out_stall)) begin
      out_re_r <= ore[DataW-1:0];
      out_im_r <= oim[DataW-1:0];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_bin_re   = out_re_r;
  assign out_bin_im   = out_im_r;
  assign out_last_bin = out_last_r && out_valid_r;

  // Inputs are refused outside the load phase
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_LOAD) |-> in_stall)
    else $error("input taken during transform");

  // A stalled result holds its value
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_bin_re) && $stable(out_bin_im)))
    else $error("result changed while stalled");

  // Load count stays below the store depth while loading
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> (load_cnt_r < CntW'(Depth)))
    else $error("load count overrun");

endmodule

@@ tb/sv/tb_radix2_fft_engine_unit.sv @@
// Self-checking testbench of the radix-2 FFT engine: random and directed transforms
`timescale 1ns / 1ps

module tb_radix2_fft_engine_unit;
  import r2fft_pkg::*;

  typedef struct {
    logic signed [22:0] re;
    logic signed [22:0] im;
    logic               last;
  } fft_bin_t;

  // Predicts bins of each transform and checks the emitted ones in order
  class fft_scoreboard;
    int unsigned      len_cfg;
    bit               inv_cfg;
    longint           store_re[64];
    longint           store_im[64];
    int unsigned      fill;
    fft_bin_t         pending[$];
    int unsigned      errors;

    function new();
      len_cfg = 6;
      inv_cfg = 0;
      fill    = 0;
      errors  = 0;
    endfunction

    function void write_cfg(logic [0:0] idx, logic [2:0] val);
      if (idx == CfgLog2) len_cfg = val;
      else inv_cfg = val[0];
    endfunction

    static function longint floor_shr(longint v, int sh);
      return v >>> sh;
    endfunction

    static function longint clip23(longint v);
      if (v > 4194303) return 4194303;
      if (v < -4194304) return -4194304;
      return v;
    endfunction

    static function void twiddle_at(int unsigned k, output longint c, output longint s);
      int qc[17];
      qc = '{32768, 32610, 32138, 31357, 30274, 28899, 27246, 25330, 23170,
             20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
      k = k & 31;
      if (k <= 16) begin
        c = qc[k];
        s = qc[16 - k];
      end else begin
        c = -qc[32 - k];
        s = qc[k - 16];
      end
    endfunction

    // Note one accepted sample; run the transform when the length is reached
    function void note_sample(logic signed [15:0] sre, logic signed [15:0] sim);
      longint xr[64], xi[64];
      longint c, s, tr, ti, ar, ai;
      int unsigned len, n, r, a, b, half, v;
      fft_bin_t bin;
      len = (len_cfg < 1) ? 1 : (len_cfg > 6 ? 6 : len_cfg);
      n = 1 << len;
      if (fill < 64) begin
        store_re[fill] = sre;
        store_im[fill] = sim;
      end
      fill++;
      if (fill < n) return;
      fill = 0;
      for (int unsigned i = 0; i < n; i++) begin
        r = 0;
        v = i;
        for (int unsigned q = 0; q < len; q++) begin
          r = (r << 1) | (v & 1);
          v >>= 1;
        end
        xr[i] = store_re[r];
        xi[i] = inv_cfg ? -store_im[r] : store_im[r];
      end
      for (int unsigned st = 0; st < len; st++) begin
        half = 1 << st;
        for (int unsigned k = 0; k < n; k += 2 * half) begin
          for (int unsigned j = 0; j < half; j++) begin
            a = k + j;
            b = a + half;
            twiddle_at(j << (5 - st), c, s);
            tr = floor_shr(c * xr[b] + s * xi[b] + 16384, 15);
            ti = floor_shr(c * xi[b] - s * xr[b] + 16384, 15);
            ar = xr[a];
            ai = xi[a];
            xr[b] = clip23(ar - tr);
            xi[b] = clip23(ai - ti);
            xr[a] = clip23(ar + tr);
            xi[a] = clip23(ai + ti);
          end
        end
      end
      for (int unsigned i = 0; i < n; i++) begin
        if (inv_cfg) begin
          bin.re = floor_shr(xr[i], len);
          bin.im = floor_shr(-xi[i], len);
        end else begin
          bin.re = xr[i];
          bin.im = xi[i];
        end
        bin.last = (i == n - 1);
        pending.push_back(bin);
      end
    endfunction

    // Compare one emitted bin with the oldest predicted one
    function void check_bin(logic signed [22:0] re, logic signed [22:0] im, logic last);
      fft_bin_t exp_bin;
      if (pending.size() == 0) begin
        $error("unexpected bin re=%0d im=%0d", re, im);
        errors++;
        return;
      end
      exp_bin = pending.pop_front();
      if (re !== exp_bin.re) begin
        $error("bin_re expected %0d actual %0d", exp_bin.re, re);
        errors++;
      end
      if (im !== exp_bin.im) begin
        $error("bin_im expected %0d actual %0d", exp_bin.im, im);
        errors++;
      end
      if (last !== exp_bin.last) begin
        $error("last_bin expected %0d actual %0d", exp_bin.last, last);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 0;
  logic              rst_n = 0;
  logic              cfg_wr_en = 0;
  logic [0:0]        cfg_index = CfgLog2;
  logic [2:0]        cfg_data = '0;
  logic              in_valid = 0;
  logic              in_stall;
  logic signed [15:0] in_sample_re = '0;
  logic signed [15:0] in_sample_im = '0;
  logic              out_valid;
  logic              out_stall = 1;
  logic signed [22:0] out_bin_re;
  logic signed [22:0] out_bin_im;
  logic              out_last_bin;

  fft_scoreboard sb = new();
  bit            hold_long = 0;
  bit            sink_busy = 0;

  radix2_fft_engine_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample_re (in_sample_re),
    .in_sample_im (in_sample_im),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_bin_re   (out_bin_re),
    .out_bin_im   (out_bin_im),
    .out_last_bin (out_last_bin)
  );

  always #4 clk = ~clk;

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Check every emitted bin at the edge where it is taken
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_bin(out_bin_re, out_bin_im, out_last_bin);
  end

  // Drive the receiver stall: random gaps, or a long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b1;
    end else if (hold_long) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 30) ? (gap_len() != 0) : 1'b0;
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [2:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.write_cfg(idx, val);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Offer one sample and hold it until the transaction is taken
  task automatic send_sample(logic signed [15:0] sre, logic signed [15:0] sim, bit idle);
    int unsigned g;
    g = idle ? gap_len() : 0;
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_re <= sre;
    in_sample_im <= sim;
    do @(posedge clk); while (in_stall);
    sb.note_sample(sre, sim);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return $urandom_range(0, 15) - 8;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Drop the input, wait for all predicted bins, then let the engine settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic run_block(int unsigned count, bit idle);
    for (int unsigned i = 0; i < count; i++)
      send_sample(rand_sample(), rand_sample(), idle);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes at two points, forward and inverse
    write_reg(CfgLog2, 3'd1);
    send_sample(16'sh7FFF, 16'sh8000, 0);
    send_sample(16'sh8000, 16'sh7FFF, 0);
    send_sample(16'sh7FFF, 16'sh7FFF, 1);
    send_sample(16'sh7FFF, 16'sh7FFF, 1);
    drain();
    write_reg(CfgInv, 3'd1);
    send_sample(16'sh8000, 16'sh8000, 0);
    send_sample(16'sh8000, 16'sh8000, 0);
    drain();
    // Length zero acts as two points
    write_reg(CfgLog2, 3'd0);
    send_sample(16'sh0001, 16'shFFFF, 0);
    send_sample(16'sh5555, 16'shAAAA, 0);
    drain();
    // Impulse at eight points, forward
    write_reg(CfgInv, 3'd0);
    write_reg(CfgLog2, 3'd3);
    send_sample(16'sh7FFF, 16'sh0000, 0);
    for (int i = 0; i < 7; i++) send_sample(16'sh0000, 16'sh0000, 0);
    drain();

    // Random phases through several lengths and both modes
    write_reg(CfgLog2, 3'd7);
    write_reg(CfgInv, 3'd1);
    run_block(64, 1);
    drain();
    write_reg(CfgLog2, 3'd4);
    write_reg(CfgInv, 3'd0);
    // Long receiver hold-off while samples keep coming
    fork
      begin
        hold_long = 1;
        repeat (300) @(posedge clk);
        hold_long = 0;
      end
      run_block(32, 0);
    join
    drain();
    write_reg(CfgInv, 3'd1);
    run_block(16, 1);
    drain();
    write_reg(CfgLog2, 3'd2);
    write_reg(CfgInv, 3'd0);
    run_block(8, 1);
    drain();
    write_reg(CfgLog2, 3'd6);
    write_reg(CfgInv, 3'd0);
    run_block(64, 1);
    drain();

    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #4ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
design/r2fft_pkg.sv
design/r2fft_ram.sv
design/r2fft_bfly.sv
design/radix2_fft_engine_unit.sv
tb/sv/tb_radix2_fft_engine_unit.sv
